// File: rtl/rcdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdc_pkg: shared types and codes of the run collapse dedup cache
// Request payload structs, result cause codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rcdc_pkg;

  localparam int FIELD_BITS = 64;

  // Result cause codes.
  localparam logic CAUSE_EVICT = 1'b0;
  localparam logic CAUSE_FLUSH = 1'b1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] group_key;
    logic                  range_end;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] out_key;
    logic                  cause;
    logic                  final_of_burst;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EVICT,
    ST_FLUSH
  } state_t;

endpackage

// File: rtl/rcdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rcdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/run_collapse_dedup_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_collapse_dedup_cache_top: run collapse ahead of a set-associative cache
// Collapses runs of equal keys, deduplicates finished runs in a bucket cache
// and passes evicted keys and range-final keys downstream.
// ----------------------------------------------------------------------------
// Usage. Requests enter on in_valid/in_ready/in_data (a key and a range end
// flag). Results leave on out_valid/out_ready/out_data, each with its key,
// its cause (evicted or flushed at range end) and a flag on the last result
// that one request caused. A request causes zero, one or two results.
//
// Timing. A request that continues the open run, or opens a new one, is
// accepted in the idle state and needs no lookup. A request that ends a run
// looks up the bucket: the request is accepted, the bucket row is read
// through the registered read port, then the ways are compared one at a time
// by the single shared key comparator, up to WAYS of them. Each result then
// loads the output register. The lookup is a read-modify-write of the bucket
// memory with a way-serial compare.
//
// Reset. After rst_n the bucket fill counts are cleared by a pass over all
// 2**INDEX_BITS buckets, one per cycle; in_ready stays low during the pass.
//
// Stalls. Results sit in an output register. The block accepts a request
// while a result waits there; it waits on that register only once it needs
// it again for a new result.
// ----------------------------------------------------------------------------
module run_collapse_dedup_cache_top
  import rcdc_pkg::*;
#(
  parameter int WAYS       = 4,
  parameter int INDEX_BITS = 10,
  parameter int KEY_BITS   = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int SETS  = 2 ** INDEX_BITS;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = CNT_W + WAYS * KEY_BITS;

  // Sequencer state.
  state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic [WAY_W-1:0]      way_r, way_nxt;

  // Run tracking.
  logic [KEY_BITS-1:0] held_key_r;
  logic                held_present_r;
  logic [KEY_BITS-1:0] lk_key_r;     // key of the finished run being looked up
  logic                flush_r;      // this request also ends its range

  // Bucket row captured from memory: fill count and keys.
  logic [CNT_W-1:0]                 row_cnt_r;
  logic [WAYS-1:0][KEY_BITS-1:0]    row_keys_r;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  // Memory port signals.
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [INDEX_BITS-1:0] ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;

  logic [KEY_BITS-1:0]   in_key;
  logic                  in_acc;
  logic                  run_ends;
  logic [INDEX_BITS-1:0] lk_set;
  logic [63:0]           held_ext;
  logic [63:0]           lk_ext;

  // Shared compare unit and row update values.
  logic [KEY_BITS-1:0]           cur_key;
  logic                          cur_valid;
  logic                          cur_eq;
  logic                          last_way;
  logic [WAYS-1:0][KEY_BITS-1:0] keys_ins;
  logic [WAYS-1:0][KEY_BITS-1:0] keys_shift;

  logic      out_free;
  logic      out_load;
  out_item_t out_next;

  assign in_key   = in_data.group_key[KEY_BITS-1:0];
  assign in_acc   = in_valid && in_ready;
  assign run_ends = held_present_r && (in_key != held_key_r);

  // The bucket index is the low bits of the key, zero above KEY_BITS.
  assign held_ext  = 64'(held_key_r);
  assign lk_ext    = 64'(lk_key_r);
  assign ram_raddr = held_ext[INDEX_BITS-1:0];
  assign lk_set    = lk_ext[INDEX_BITS-1:0];

  assign cur_key   = row_keys_r[way_r];
  assign cur_valid = CNT_W'(way_r) < row_cnt_r;
  assign cur_eq    = cur_key == lk_key_r;
  assign last_way  = way_r == WAY_W'(WAYS - 1);

  always_comb begin
    keys_ins         = row_keys_r;
    keys_ins[way_r]  = lk_key_r;
    keys_shift[0]    = lk_key_r;
    for (int s = 1; s < WAYS; s++) begin
      keys_shift[s] = row_keys_r[s-1];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  rcdc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    way_nxt   = way_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == {INDEX_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (run_ends) begin
            state_nxt = ST_READ;
          end else if (in_data.range_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_READ: begin
        way_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Hit or empty way ends the scan; a miss on the last valid way evicts.
        if (!cur_valid || cur_eq) begin
          state_nxt = flush_r ? ST_FLUSH : ST_IDLE;
        end else if (last_way) begin
          state_nxt = ST_EVICT;
        end else begin
          way_nxt = way_r + 1'b1;
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          state_nxt = flush_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = lk_set;
    ram_wdata = {row_cnt_r, row_keys_r};
    out_load  = 1'b0;
    out_next  = '{out_key: 64'(held_key_r), cause: CAUSE_FLUSH, final_of_burst: 1'b1};
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
      end
      ST_SCAN: begin
        if (!cur_valid) begin
          ram_we    = 1'b1;
          ram_wdata = {row_cnt_r + 1'b1, keys_ins};
        end else if (!cur_eq && last_way) begin
          ram_we    = 1'b1;
          ram_wdata = {row_cnt_r, keys_shift};
        end
      end
      ST_EVICT: begin
        out_load = out_free;
        out_next = '{out_key: 64'(row_keys_r[WAYS-1]), cause: CAUSE_EVICT,
                     final_of_burst: !flush_r};
      end
      ST_FLUSH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      way_r          <= '0;
      held_key_r     <= '0;
      held_present_r <= 1'b0;
      flush_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      way_r   <= way_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (in_acc) begin
        if (!held_present_r || run_ends) begin
          held_key_r <= in_key;
        end
        held_present_r <= !in_data.range_end;
        flush_r        <= in_data.range_end;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lk_key_r <= held_key_r;
    end
    if (state_r == ST_READ) begin
      row_cnt_r  <= ram_rdata[ROW_W-1 -: CNT_W];
      row_keys_r <= ram_rdata[WAYS*KEY_BITS-1:0];
    end
    if (out_load) begin
      out_data_r <= out_next;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/rcdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdc_checker: port-level checks for the run collapse dedup cache
// Watches the top level's channels and is bound to every instance.
// ----------------------------------------------------------------------------
module rcdc_checker
  import rcdc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A range flush is always the last result of its request.
  a_flush_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cause == CAUSE_FLUSH |-> out_data.final_of_burst)
    else $error("flush result not marked final");

  // While an eviction awaits its flush, no new request is taken.
  a_evict_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cause == CAUSE_EVICT && !out_data.final_of_burst
      |-> !in_ready)
    else $error("request accepted before pending flush");

endmodule

bind run_collapse_dedup_cache_top rcdc_checker u_rcdc_checker (.*);
